// ===== rtl/cobs_xor_frame_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// cobs_xor_frame_encoder_assert.svh
// assertion macros used by the frame encoder back end
// ----------------------------------------------------------------------------
`ifndef COBS_XOR_FRAME_ENCODER_ASSERT_SVH
`define COBS_XOR_FRAME_ENCODER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define CXFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cxfe: implication check failed");

// next-cycle implication
`define CXFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cxfe: next-cycle check failed");

`else

`define CXFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CXFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/cxfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cxfe_pkg
// constants, command codes and the command type of the frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package cxfe_pkg;

	// packet length limit, checksum not counted
	localparam int MAX_LEN = 60;

	// block store: holds up to MAX_LEN data bytes plus the checksum
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// accepted-byte counter width
	localparam int PCNT_W = $clog2(MAX_LEN + 1);

	// command queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// command codes
	localparam logic [1:0] CMD_PUSH      = 2'd0;
	localparam logic [1:0] CMD_FLUSH     = 2'd1;
	localparam logic [1:0] CMD_FLUSH_END = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       err;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/cxfe_if.sv =====
// ----------------------------------------------------------------------------
// cxfe_if
// valid/ready channels for raw packet bytes and encoded frame bytes
// ----------------------------------------------------------------------------
`default_nettype none

// raw packet bytes
interface cxfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// encoded frame bytes
interface cxfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_frame;
	logic       length_error;

	modport source (output valid, output out_byte, output end_of_frame,
		output length_error, input ready);
	modport sink   (input valid, input out_byte, input end_of_frame,
		input length_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/cxfe_front.sv =====
// ----------------------------------------------------------------------------
// cxfe_front
// accepts packet bytes, keeps the xor and length limit, issues block commands
// ----------------------------------------------------------------------------
`default_nettype none

module cxfe_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cxfe_in_if.sink            pkt,
	output logic               push,
	output cxfe_pkg::cmd_t     cmd,
	input  wire logic          full
);
	import cxfe_pkg::*;

	localparam logic [1:0] FR_TAKE = 2'd0;
	localparam logic [1:0] FR_SUM  = 2'd1;
	localparam logic [1:0] FR_END  = 2'd2;

	logic [1:0]        phase_q;
	logic [7:0]        xor_q;
	logic [PCNT_W-1:0] pcnt_q;
	logic              ovf_q;
	logic              err_q;

	logic take;
	logic acc;
	logic [7:0] xor_next;

	// byte is kept while under the length limit
	assign take     = pcnt_q < PCNT_W'(MAX_LEN);
	assign acc      = pkt.valid && pkt.ready;
	assign xor_next = take ? (xor_q ^ pkt.data_byte) : xor_q;

	assign pkt.ready = (phase_q == FR_TAKE) && !full;

	// command issue
	always_comb begin
		push     = 1'b0;
		cmd.kind = CMD_PUSH;
		cmd.data = pkt.data_byte;
		cmd.err  = 1'b0;
		unique case (phase_q)
			FR_TAKE: begin
				push     = acc && take;
				cmd.kind = (pkt.data_byte == 8'd0) ? CMD_FLUSH : CMD_PUSH;
			end
			FR_SUM: begin
				push     = !full;
				cmd.data = xor_q;
				cmd.kind = (xor_q == 8'd0) ? CMD_FLUSH : CMD_PUSH;
			end
			FR_END: begin
				push     = !full;
				cmd.kind = CMD_FLUSH_END;
				cmd.err  = err_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= FR_TAKE;
			xor_q   <= '0;
			pcnt_q  <= '0;
			ovf_q   <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			unique case (phase_q)
				FR_TAKE: begin
					if (acc) begin
						xor_q <= xor_next;
						if (take) begin
							pcnt_q <= pcnt_q + PCNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (pkt.last_byte) begin
							err_q   <= ovf_q || !take;
							phase_q <= FR_SUM;
						end
					end
				end
				FR_SUM: begin
					if (!full) begin
						phase_q <= FR_END;
					end
				end
				FR_END: begin
					if (!full) begin
						phase_q <= FR_TAKE;
						xor_q   <= '0;
						pcnt_q  <= '0;
						ovf_q   <= 1'b0;
						err_q   <= 1'b0;
					end
				end
				default: begin
					phase_q <= FR_TAKE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cxfe_queue.sv =====
// ----------------------------------------------------------------------------
// cxfe_queue
// short command fifo between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module cxfe_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cxfe_pkg::cmd_t cmd_in,
	output logic               full,
	input  wire logic          pop,
	output cxfe_pkg::cmd_t     cmd_out,
	output logic               nempty
);
	import cxfe_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full    = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign nempty  = cnt_q != '0;
	assign cmd_out = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cxfe_back.sv =====
// ----------------------------------------------------------------------------
// cxfe_back
// block store and emitter: code word, block bytes, delimiter
// ----------------------------------------------------------------------------
`default_nettype none
`include "cobs_xor_frame_encoder_assert.svh"

module cxfe_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cxfe_pkg::cmd_t cmd,
	input  wire logic          nempty,
	output logic               pop,
	cxfe_out_if.source         enc
);
	import cxfe_pkg::*;

	localparam logic [1:0] BK_IDLE  = 2'd0;
	localparam logic [1:0] BK_CODE  = 2'd1;
	localparam logic [1:0] BK_DATA  = 2'd2;
	localparam logic [1:0] BK_DELIM = 2'd3;

	logic [7:0] mem [STORE_DEPTH];

	logic [1:0]        state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              end_q, end_d;
	logic              err_q, err_d;
	logic [7:0]        rd_data_q;

	logic              ov_q;
	logic [7:0]        ob_q;
	logic              oeof_q;
	logic              oerr_q;

	logic       load_ok;
	logic       wr_en;
	logic       ld;
	logic [7:0] ld_byte;
	logic       ld_eof;
	logic       ld_err;

	assign load_ok = !ov_q || enc.ready;

	assign enc.valid        = ov_q;
	assign enc.out_byte     = ob_q;
	assign enc.end_of_frame = oeof_q;
	assign enc.length_error = oerr_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		end_d   = end_q;
		err_d   = err_q;
		pop     = 1'b0;
		wr_en   = 1'b0;
		ld      = 1'b0;
		ld_byte = rd_data_q;
		ld_eof  = 1'b0;
		ld_err  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				idx_d = '0;
				if (nempty) begin
					pop = 1'b1;
					if (cmd.kind == CMD_PUSH) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + ADDR_W'(1);
					end else begin
						end_d   = cmd.kind == CMD_FLUSH_END;
						err_d   = cmd.err;
						state_d = BK_CODE;
					end
				end
			end
			BK_CODE: begin
				if (load_ok) begin
					ld      = 1'b1;
					ld_byte = 8'(cnt_q) + 8'd1;
					if (cnt_q == '0) begin
						state_d = end_q ? BK_DELIM : BK_IDLE;
					end else begin
						state_d = BK_DATA;
					end
				end
			end
			BK_DATA: begin
				if (load_ok) begin
					ld    = 1'b1;
					idx_d = idx_q + ADDR_W'(1);
					if (idx_d == cnt_q) begin
						cnt_d   = '0;
						state_d = end_q ? BK_DELIM : BK_IDLE;
					end
				end
			end
			BK_DELIM: begin
				if (load_ok) begin
					ld      = 1'b1;
					ld_byte = 8'd0;
					ld_eof  = 1'b1;
					ld_err  = err_q;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// block store, registered read at the next index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q] <= cmd.data;
		end
		rd_data_q <= mem[idx_d];
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (ld) begin
			ob_q   <= ld_byte;
			oeof_q <= ld_eof;
			oerr_q <= ld_err;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			end_q   <= 1'b0;
			err_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			end_q   <= end_d;
			err_q   <= err_d;
			if (ld) begin
				ov_q <= 1'b1;
			end else if (enc.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// checks
	`CXFE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= ADDR_W'(MAX_LEN + 1))
	`CXFE_ASSERT_IMP(a_idx_in_block, clk, arst_n, state_q == BK_DATA, idx_q < cnt_q)
	`CXFE_ASSERT_IMP(a_delim_empty, clk, arst_n, state_q == BK_DELIM, cnt_q == '0)
	`CXFE_ASSERT_NXT(a_delim_done, clk, arst_n, state_q == BK_DELIM && load_ok, state_q == BK_IDLE && oeof_q)

endmodule

`default_nettype wire

// ===== rtl/cobs_xor_frame_encoder.sv =====
// Path: closing command -> queue slot -> BK_CODE state -> code word in the output register.
// Throughput: a non-final byte is taken each cycle while the 4-entry command queue has room;
// a final byte then blocks the input while the checksum and frame close commands go out.
// Output, per block: one word per cycle while enc.ready, code + n bytes, delimiter if last.
// Reset: arst_n clears all control state at once; the block store is not cleared.
`default_nettype none

// ----------------------------------------------------------------------------
// cobs_xor_frame_encoder
// cobs frame encoder with xor checksum byte, length limit and error flag
// ----------------------------------------------------------------------------

module cobs_xor_frame_encoder (
	input  wire logic clk,
	input  wire logic arst_n,
	cxfe_in_if.sink   pkt,
	cxfe_out_if.source enc
);
	import cxfe_pkg::*;

	logic push;
	logic full;
	logic pop;
	logic nempty;
	cmd_t cmd_f;
	cmd_t cmd_b;

	// front: packet bookkeeping
	cxfe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.push   (push),
		.cmd    (cmd_f),
		.full   (full)
	);

	// command queue
	cxfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_f),
		.full    (full),
		.pop     (pop),
		.cmd_out (cmd_b),
		.nempty  (nempty)
	);

	// back: store and emit
	cxfe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_b),
		.nempty (nempty),
		.pop    (pop),
		.enc    (enc)
	);

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cobs frame encoder: bytes go in over the pkt
// channel with random bursts and gaps, encoded words come back over the enc
// channel under a stalling receiver and are checked against a cobs/xor
// model held in the bench, including over-length packets
// ----------------------------------------------------------------------------

module tb;

	localparam int HALF_PERIOD = 10;
	localparam int RUN_LIMIT   = 254;
	localparam int RAND_BYTES  = 180;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 50;
	localparam int LONG_HOLD   = 400;
	localparam int N_DIR       = 20;

	// one encoded word as seen on the enc channel
	typedef struct packed {
		logic [7:0] data;
		logic       eof;
		logic       err;
	} frame_word_t;

	// directed row: n == 0 means the model alone predicts the row
	typedef struct packed {
		logic [7:0]      d;
		logic            l;
		logic [2:0]      n;
		logic [0:5][7:0] exp;
	} dir_row_t;

	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{8'h00, 1'b1, 3'd4, 48'h01_01_01_00_00_00},
		'{8'hFF, 1'b1, 3'd4, 48'h03_FF_FF_00_00_00},
		'{8'h55, 1'b1, 3'd4, 48'h03_55_55_00_00_00},
		'{8'h12, 1'b0, 3'd0, 48'h0},
		'{8'h12, 1'b1, 3'd5, 48'h03_12_12_01_00_00},
		'{8'h00, 1'b0, 3'd0, 48'h0},
		'{8'h00, 1'b1, 3'd4, 48'h01_01_01_00_00_00},
		'{8'h80, 1'b0, 3'd0, 48'h0},
		'{8'h01, 1'b0, 3'd0, 48'h0},
		'{8'h00, 1'b0, 3'd0, 48'h0},
		'{8'hAA, 1'b0, 3'd0, 48'h0},
		'{8'h2B, 1'b1, 3'd0, 48'h0},
		'{8'h7F, 1'b0, 3'd0, 48'h0},
		'{8'hFE, 1'b1, 3'd0, 48'h0},
		'{8'h01, 1'b1, 3'd4, 48'h03_01_01_00_00_00},
		'{8'h00, 1'b0, 3'd0, 48'h0},
		'{8'hFF, 1'b0, 3'd0, 48'h0},
		'{8'h00, 1'b0, 3'd0, 48'h0},
		'{8'hFF, 1'b1, 3'd0, 48'h0},
		'{8'hC3, 1'b1, 3'd0, 48'h0}
	};

	logic clk;
	logic arst_n;

	cxfe_in_if  pkt ();
	cxfe_out_if enc ();

	cobs_xor_frame_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt),
		.enc    (enc)
	);

	// encoder model state
	logic [7:0]  run_xor   = 8'h00;
	logic [7:0]  open_blk[$];
	int          pkt_len   = 0;
	logic        dropped   = 1'b0;
	frame_word_t frame_q[$];

	// bookkeeping
	int err_cnt    = 0;
	int cyc        = 0;
	int bytes_in   = 0;
	int pkts       = 0;
	int ovf_pkts   = 0;
	int words_seen = 0;
	int burst_left = 0;
	bit gaps_on    = 1'b1;
	int hold_req   = 0;
	int n_added    = 0;
	frame_word_t mon_w;

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cyc, frame_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at word %0d: %s got %0h expected %0h", words_seen, what, got, want);
		err_cnt++;
	endtask

	function void push_word(input logic [7:0] b, input logic eof, input logic err);
		frame_word_t w;
		w.data = b;
		w.eof  = eof;
		w.err  = err;
		frame_q.push_back(w);
	endfunction

	// emit code word and the bytes of the open block
	function void close_block();
		logic [7:0] code;
		code = 8'(open_blk.size() + 1);
		push_word(code, 1'b0, 1'b0);
		foreach (open_blk[i])
			push_word(open_blk[i], 1'b0, 1'b0);
		open_blk.delete();
	endfunction

	function void cobs_byte(input logic [7:0] b);
		if (b == 8'h00) begin
			close_block();
		end else begin
			open_blk.push_back(b);
			if (open_blk.size() >= RUN_LIMIT)
				close_block();
		end
	endfunction

	// predict the words caused by one accepted byte
	function void predict_encoding(input logic [7:0] d, input logic l);
		logic e;
		if (pkt_len < cxfe_pkg::MAX_LEN) begin
			run_xor ^= d;
			pkt_len++;
			cobs_byte(d);
		end else begin
			dropped = 1'b1;
		end
		if (l) begin
			e = dropped;
			cobs_byte(run_xor);
			close_block();
			push_word(8'h00, 1'b1, e);
			pkts++;
			if (e)
				ovf_pkts++;
			run_xor = 8'h00;
			pkt_len = 0;
			dropped = 1'b0;
		end
	endfunction

	// drive one byte and hold it until taken
	task automatic offer(input logic [7:0] d, input logic l);
		@(negedge clk);
		pkt.valid     = 1'b1;
		pkt.data_byte = d;
		pkt.last_byte = l;
		do @(posedge clk); while (!pkt.ready);
		bytes_in++;
	endtask

	task automatic idle_gap(input int n);
		repeat (n) begin
			@(negedge clk);
			pkt.valid = 1'b0;
		end
	endtask

	// bursty sender with model update on acceptance
	task automatic send_byte(input logic [7:0] d, input logic l);
		int n_before;
		if (burst_left == 0) begin
			if (gaps_on)
				idle_gap($urandom_range(1, 6));
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		offer(d, l);
		n_before = frame_q.size();
		predict_encoding(d, l);
		n_added = frame_q.size() - n_before;
	endtask

	task automatic send_packet(input int len, input int zero_pct);
		logic [7:0] d;
		for (int i = 0; i < len; i++) begin
			d = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
			send_byte(d, i == len - 1);
		end
	endtask

	// stop offering, then wait for every expected word
	task automatic wait_drained();
		@(negedge clk);
		pkt.valid = 1'b0;
		while (frame_q.size() != 0)
			@(posedge clk);
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n && enc.valid && enc.ready) begin
			if (frame_q.size() == 0) begin
				report("unexpected word", enc.out_byte, 0);
			end else begin
				mon_w = frame_q.pop_front();
				if (enc.out_byte !== mon_w.data)
					report("out_byte", enc.out_byte, mon_w.data);
				if (enc.end_of_frame !== mon_w.eof)
					report("end_of_frame", enc.end_of_frame, mon_w.eof);
				if (enc.length_error !== mon_w.err)
					report("length_error", enc.length_error, mon_w.err);
			end
			words_seen++;
		end
	end

	// receiver: modes change now and then, long hold on request
	initial begin
		int         hold_left;
		int         mode_left;
		int         rx_mode;
		logic [7:0] stall_pat;
		hold_left = 0;
		mode_left = 0;
		rx_mode   = 0;
		stall_pat = 8'b1011_0110;
		enc.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (mode_left == 0) begin
				rx_mode   = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			stall_pat = {stall_pat[6:0], stall_pat[7]};
			if (hold_left > 0) begin
				hold_left--;
				enc.ready = 1'b0;
			end else begin
				case (rx_mode)
					0: enc.ready = 1'b1;
					1: enc.ready = stall_pat[0];
					2: enc.ready = ($urandom_range(0, 3) != 0);
					default: enc.ready = ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// stimulus
	initial begin
		int n0;
		int kind;
		pkt.valid     = 1'b0;
		pkt.data_byte = 8'h00;
		pkt.last_byte = 1'b0;
		arst_n        = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int r = 0; r < N_DIR; r++) begin
			send_byte(DIR_TAB[r].d, DIR_TAB[r].l);
			if (DIR_TAB[r].n != 0) begin
				repeat (n_added)
					void'(frame_q.pop_back());
				for (int k = 0; k < DIR_TAB[r].n; k++)
					push_word(DIR_TAB[r].exp[k], k == DIR_TAB[r].n - 1, 1'b0);
			end
		end

		// receiver holds off while an over-length packet streams in
		wait_drained();
		hold_req = LONG_HOLD;
		gaps_on  = 1'b0;
		send_packet(64, 10);
		wait_drained();

		// random packets, mostly short, some at and over the length limit
		n0 = bytes_in;
		while (bytes_in - n0 < RAND_BYTES) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			kind    = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3: send_packet($urandom_range(1, 12), 25);
				4, 5:       send_packet($urandom_range(1, 12), 0);
				6:          send_packet($urandom_range(13, 59), 15);
				7:          send_packet(cxfe_pkg::MAX_LEN + $urandom_range(0, 1), 10);
				8:          send_packet($urandom_range(1, 4), 70);
				default:    send_packet($urandom_range(61, 70), 20);
			endcase
		end

		@(negedge clk);
		pkt.valid = 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("sent %0d bytes in %0d packets, %0d of them over the length limit",
			bytes_in, pkts, ovf_pkts);
		$display("checked %0d encoded words in %0d cycles, %0d mismatches",
			words_seen, cyc, err_cnt);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cxfe_pkg.sv
rtl/cxfe_if.sv
rtl/cxfe_front.sv
rtl/cxfe_queue.sv
rtl/cxfe_back.sv
rtl/cobs_xor_frame_encoder.sv
verif/tb.sv
